/* hw/rtl/pmau_pkg.sv */
`default_nettype none
package pmau_pkg;

  localparam int unsigned MEM_BYTES_DEF   = 65536;
  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_BYTES      = 4096;
  localparam int unsigned PG_SHIFT        = 12;
  localparam int unsigned VPN_BITS        = 32 - PG_SHIFT;
  localparam int unsigned TAG_BITS        = 32 + VPN_BITS;

  localparam logic [31:0] DIRECT_LIMIT = 32'h0800_0000;
  localparam logic [31:0] BIT_PRESENT  = 32'h0000_0001;
  localparam logic [31:0] BIT_ACCESSED = 32'h0000_0020;
  localparam logic [31:0] BIT_DIRTY    = 32'h0000_0040;
  localparam logic [31:0] OFF_MASK     = 32'h0000_0fff;

  localparam logic CFG_PAGING_ENABLE = 1'b0;
  localparam logic CFG_PAGE_DIR_BASE = 1'b1;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_OUT_RANGE  = 2'd2,
    ST_CROSS_WR   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_XLAT, S_SLOT, S_TLB_RD, S_TLB_CHK,
    S_PTE_HIT, S_PDE, S_PDE_NEXT, S_PTE, S_PTE_FILL, S_XPA, S_XDONE,
    S_CROSS1, S_CROSS2, S_DATA_DONE, S_FIN, S_RD_A, S_RD_D, S_WR_B
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/paged_memory_access_unit.sv */
// paged memory access unit
// input channel (in_*): one read or write of 1 to 4 little-endian bytes at a
// virtual address; in_tuser carries the request type (0 read, 1 write).
// result channel (out_*): one transfer per request with read data, physical
// address and status (0 ok, 1 not present, 2 out of range, 3 cross-page write).
// config channel (cfg_*): index 0 paging enable, index 1 page directory base;
// always ready; the user must see that it is written only while no request is in flight.
// the block does not enforce this. a request runs on one byte-wide memory
// port, each byte read via S_RD_A and S_RD_D and each written via S_WR_B;
// a paged access below 0x8000000 keeps its address, above it looks up the tlb
// (reciprocal slot index, a 4-byte entry read and write-back on a hit) or walks
// directory and table, and a cross-page read translates twice.
// the block takes a new request only when idle and the result register empty,
// at the earliest in the cycle after the result transfer;
// a stalled receiver holds the result and blocks further requests.
// after reset the byte memory is cleared one byte a cycle, all MEM_BYTES of it,
// before the first request is accepted; tlb valid bits clear at once.
`default_nettype none
module paged_memory_access_unit #(
  parameter int unsigned MEM_BYTES   = pmau_pkg::MEM_BYTES_DEF,
  parameter int unsigned TLB_ENTRIES = pmau_pkg::TLB_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // virt_addr[31:0], access_len[34:32], write_data[66:35]
  input  wire logic [0:0]  in_tuser,   // req_type[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // read_data[31:0], phys_addr[63:32], status[65:64]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW  = $clog2(MEM_BYTES);
  localparam int unsigned SW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned TW  = pmau_pkg::TAG_BITS + AW;
  localparam int unsigned VB  = pmau_pkg::VPN_BITS;
  localparam int unsigned SL  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 0;
  localparam int unsigned RS  = VB + SL;
  localparam logic [VB:0] RECIP =
    (VB+1)'(((64'd1 << RS) + 64'(TLB_ENTRIES) - 64'd1) / 64'(TLB_ENTRIES));
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
  localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

  function automatic logic in_mem(input logic [31:0] a, input logic [2:0] n);
    in_mem = ({1'b0, a} + 33'(n)) <= MEM_LIMIT;
  endfunction

  pmau_pkg::state_t  state_r, state_nxt, ret_r, ret_nxt;
  pmau_pkg::status_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt, addr_r, addr_nxt, loc_r, loc_nxt;
  logic          is_wr_r, is_wr_nxt, part_r, part_nxt, xwr_r, xwr_nxt;
  logic [31:0]   va_r, va_nxt, wd_r, wd_nxt, pa_r, pa_nxt, dl_r, dl_nxt;
  logic [31:0]   cva_r, cva_nxt, ent_r, ent_nxt, xpa_r, xpa_nxt;
  logic [31:0]   acc_r, acc_nxt, wdat_r, wdat_nxt, data_r, data_nxt;
  logic [2:0]    len_r, len_nxt, left_r, left_nxt, n_r, n_nxt;
  logic [1:0]    bcnt_r, bcnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [VB-1:0] quo_r, quo_nxt, rem_full;
  logic [2*VB:0] rcp_prod;
  logic [4:0]    bit_r, bit_nxt;
  logic          paging_r;
  logic [31:0]   pdb_r;
  logic [TLB_ENTRIES-1:0] tlbv_r;
  logic          out_valid_r;
  logic [31:0]   out_data_r, out_pa_r;
  logic [1:0]    out_st_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          tlb_we;
  logic [TW-1:0] tlb_wdata, tlb_rdata;
  logic [SW-1:0] slot;

  logic [2:0]  in_len;
  logic [31:0] end_va, cb, pde_loc, pte_loc;
  logic        in_acc;

  assign slot = rem_r;

  pmau_ram #(.WIDTH(8), .DEPTH(MEM_BYTES), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  pmau_ram #(.WIDTH(TW), .DEPTH(TLB_ENTRIES), .AW(SW)) u_tlb (
    .clk(clk), .we(tlb_we), .waddr(slot), .wdata(tlb_wdata),
    .raddr(slot), .rdata(tlb_rdata)
  );

  always_comb begin
    in_len = in_tdata[34:32];
    if (in_len == 3'd0) in_len = 3'd1;
    else if (in_len > 3'd4) in_len = 3'd4;
  end

  assign in_acc  = in_tvalid && in_tready;
  assign end_va  = va_r + 32'(len_r) - 32'd1;
  assign cb      = (va_r + 32'(len_r)) & ~pmau_pkg::OFF_MASK;
  assign pde_loc = (pdb_r & ~pmau_pkg::OFF_MASK) + {20'd0, cva_r[31:22], 2'b00};
  assign pte_loc = (ent_r & ~pmau_pkg::OFF_MASK) + {20'd0, cva_r[21:12], 2'b00};
  assign rcp_prod = (2*VB+1)'(cva_r[31:12]) * (2*VB+1)'(RECIP);
  assign rem_full = cva_r[31:12] - VB'(quo_r * VB'(TLB_ENTRIES));
  assign tlb_wdata = {pdb_r, cva_r[31:12], loc_r};

  // next state and datapath
  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; st_nxt = st_r;
    clr_nxt = clr_r; addr_nxt = addr_r; loc_nxt = loc_r;
    is_wr_nxt = is_wr_r; part_nxt = part_r; xwr_nxt = xwr_r;
    va_nxt = va_r; wd_nxt = wd_r; pa_nxt = pa_r; dl_nxt = dl_r;
    cva_nxt = cva_r; ent_nxt = ent_r; xpa_nxt = xpa_r;
    acc_nxt = acc_r; wdat_nxt = wdat_r; data_nxt = data_r;
    len_nxt = len_r; left_nxt = left_r; n_nxt = n_r; bcnt_nxt = bcnt_r;
    rem_nxt = rem_r; quo_nxt = quo_r; bit_nxt = bit_r;
    unique case (state_r)
      pmau_pkg::S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == MEM_LAST) state_nxt = pmau_pkg::S_IDLE;
      end
      pmau_pkg::S_IDLE: begin
        if (in_acc) begin
          is_wr_nxt = in_tuser[0];
          va_nxt = in_tdata[31:0];
          len_nxt = in_len;
          wd_nxt = in_tdata[66:35];
          pa_nxt = 32'd0; data_nxt = 32'd0; st_nxt = pmau_pkg::ST_OK;
          state_nxt = pmau_pkg::S_DISPATCH;
        end
      end
      pmau_pkg::S_DISPATCH: begin
        part_nxt = 1'b0; cva_nxt = va_r; xwr_nxt = is_wr_r;
        acc_nxt = 32'd0; bcnt_nxt = 2'd0; n_nxt = len_r;
        addr_nxt = va_r[AW-1:0]; wdat_nxt = wd_r;
        if (!paging_r) begin
          pa_nxt = va_r;
          if (!in_mem(va_r, len_r)) begin
            st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
          end else if (is_wr_r == pmau_pkg::REQ_WRITE) begin
            ret_nxt = pmau_pkg::S_FIN; state_nxt = pmau_pkg::S_WR_B;
          end else begin
            ret_nxt = pmau_pkg::S_DATA_DONE; state_nxt = pmau_pkg::S_RD_A;
          end
        end else if (end_va[31:12] != va_r[31:12]) begin
          if (is_wr_r == pmau_pkg::REQ_WRITE) begin
            st_nxt = pmau_pkg::ST_CROSS_WR; state_nxt = pmau_pkg::S_FIN;
          end else begin
            state_nxt = pmau_pkg::S_XLAT;
          end
        end else begin
          state_nxt = pmau_pkg::S_XLAT;
        end
      end
      pmau_pkg::S_XLAT: begin
        rem_nxt = '0; bit_nxt = 5'd1;
        if (cva_r < pmau_pkg::DIRECT_LIMIT) begin
          xpa_nxt = cva_r; state_nxt = pmau_pkg::S_XDONE;
        end else begin
          state_nxt = pmau_pkg::S_SLOT;
        end
      end
      pmau_pkg::S_SLOT: begin
        // slot is the page number modulo the tlb size: quotient by reciprocal
        // multiply, then the remainder from that quotient
        if (bit_r != 5'd0) begin
          quo_nxt = VB'(rcp_prod >> RS);
        end else begin
          rem_nxt = rem_full[SW-1:0];
          state_nxt = pmau_pkg::S_TLB_RD;
        end
        bit_nxt = bit_r - 5'd1;
      end
      pmau_pkg::S_TLB_RD: state_nxt = pmau_pkg::S_TLB_CHK;
      pmau_pkg::S_TLB_CHK: begin
        acc_nxt = 32'd0; bcnt_nxt = 2'd0; n_nxt = 3'd4;
        if (tlbv_r[slot] && tlb_rdata[TW-1:AW] == {pdb_r, cva_r[31:12]}) begin
          loc_nxt = tlb_rdata[AW-1:0]; addr_nxt = tlb_rdata[AW-1:0];
          ret_nxt = pmau_pkg::S_PTE_HIT; state_nxt = pmau_pkg::S_RD_A;
        end else if (!in_mem(pde_loc, 3'd4)) begin
          st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
        end else begin
          loc_nxt = pde_loc[AW-1:0]; addr_nxt = pde_loc[AW-1:0];
          ret_nxt = pmau_pkg::S_PDE; state_nxt = pmau_pkg::S_RD_A;
        end
      end
      pmau_pkg::S_PTE_HIT: begin
        ent_nxt = acc_r | pmau_pkg::BIT_ACCESSED | (xwr_r ? pmau_pkg::BIT_DIRTY : 32'd0);
        wdat_nxt = ent_nxt; addr_nxt = loc_r; bcnt_nxt = 2'd0;
        ret_nxt = pmau_pkg::S_XPA; state_nxt = pmau_pkg::S_WR_B;
      end
      pmau_pkg::S_PDE: begin
        if ((acc_r & pmau_pkg::BIT_PRESENT) == 32'd0) begin
          st_nxt = pmau_pkg::ST_NOT_PRESENT; state_nxt = pmau_pkg::S_FIN;
        end else begin
          ent_nxt = acc_r | pmau_pkg::BIT_ACCESSED;
          wdat_nxt = ent_nxt; addr_nxt = loc_r; bcnt_nxt = 2'd0;
          ret_nxt = pmau_pkg::S_PDE_NEXT; state_nxt = pmau_pkg::S_WR_B;
        end
      end
      pmau_pkg::S_PDE_NEXT: begin
        acc_nxt = 32'd0; bcnt_nxt = 2'd0; n_nxt = 3'd4;
        if (!in_mem(pte_loc, 3'd4)) begin
          st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
        end else begin
          loc_nxt = pte_loc[AW-1:0]; addr_nxt = pte_loc[AW-1:0];
          ret_nxt = pmau_pkg::S_PTE; state_nxt = pmau_pkg::S_RD_A;
        end
      end
      pmau_pkg::S_PTE: begin
        if ((acc_r & pmau_pkg::BIT_PRESENT) == 32'd0) begin
          st_nxt = pmau_pkg::ST_NOT_PRESENT; state_nxt = pmau_pkg::S_FIN;
        end else begin
          ent_nxt = acc_r | pmau_pkg::BIT_ACCESSED | (xwr_r ? pmau_pkg::BIT_DIRTY : 32'd0);
          wdat_nxt = ent_nxt; addr_nxt = loc_r; bcnt_nxt = 2'd0;
          ret_nxt = pmau_pkg::S_PTE_FILL; state_nxt = pmau_pkg::S_WR_B;
        end
      end
      pmau_pkg::S_PTE_FILL: state_nxt = pmau_pkg::S_XPA;
      pmau_pkg::S_XPA: begin
        xpa_nxt = (ent_r & ~pmau_pkg::OFF_MASK) | (cva_r & pmau_pkg::OFF_MASK);
        state_nxt = pmau_pkg::S_XDONE;
      end
      pmau_pkg::S_XDONE: begin
        acc_nxt = 32'd0; bcnt_nxt = 2'd0; addr_nxt = xpa_r[AW-1:0];
        if (!part_r) pa_nxt = xpa_r;
        if (part_r) begin
          n_nxt = len_r - left_r;
          if (!in_mem(xpa_r, n_nxt)) begin
            st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
          end else begin
            ret_nxt = pmau_pkg::S_CROSS2; state_nxt = pmau_pkg::S_RD_A;
          end
        end else if (end_va[31:12] != va_r[31:12]) begin
          left_nxt = 3'(13'h1000 - {1'b0, va_r[11:0]});
          n_nxt = left_nxt;
          if (!in_mem(xpa_r, n_nxt)) begin
            st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
          end else begin
            ret_nxt = pmau_pkg::S_CROSS1; state_nxt = pmau_pkg::S_RD_A;
          end
        end else begin
          n_nxt = len_r; wdat_nxt = wd_r;
          if (!in_mem(xpa_r, len_r)) begin
            st_nxt = pmau_pkg::ST_OUT_RANGE; state_nxt = pmau_pkg::S_FIN;
          end else if (is_wr_r == pmau_pkg::REQ_WRITE) begin
            ret_nxt = pmau_pkg::S_FIN; state_nxt = pmau_pkg::S_WR_B;
          end else begin
            ret_nxt = pmau_pkg::S_DATA_DONE; state_nxt = pmau_pkg::S_RD_A;
          end
        end
      end
      pmau_pkg::S_CROSS1: begin
        dl_nxt = acc_r; part_nxt = 1'b1; cva_nxt = cb; xwr_nxt = 1'b0;
        state_nxt = pmau_pkg::S_XLAT;
      end
      pmau_pkg::S_CROSS2: begin
        data_nxt = dl_r | (acc_r << {left_r, 3'b000});
        state_nxt = pmau_pkg::S_FIN;
      end
      pmau_pkg::S_DATA_DONE: begin
        data_nxt = acc_r; state_nxt = pmau_pkg::S_FIN;
      end
      pmau_pkg::S_FIN: state_nxt = pmau_pkg::S_IDLE;
      pmau_pkg::S_RD_A: state_nxt = pmau_pkg::S_RD_D;
      pmau_pkg::S_RD_D: begin
        acc_nxt = acc_r | ({24'd0, mem_rdata} << {bcnt_r, 3'b000});
        if (3'(bcnt_r) == n_r - 3'd1) state_nxt = ret_r;
        else begin
          bcnt_nxt = bcnt_r + 2'd1; state_nxt = pmau_pkg::S_RD_A;
        end
      end
      pmau_pkg::S_WR_B: begin
        if (3'(bcnt_r) == n_r - 3'd1) state_nxt = ret_r;
        else bcnt_nxt = bcnt_r + 2'd1;
      end
      default: state_nxt = pmau_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_we    = (state_r == pmau_pkg::S_CLEAR) || (state_r == pmau_pkg::S_WR_B);
    mem_waddr = (state_r == pmau_pkg::S_CLEAR) ? clr_r : addr_r + AW'(bcnt_r);
    mem_wdata = (state_r == pmau_pkg::S_CLEAR) ? 8'd0 : 8'(wdat_r >> {bcnt_r, 3'b000});
    mem_raddr = addr_r + AW'(bcnt_r);
    tlb_we    = (state_r == pmau_pkg::S_PTE_FILL);
    in_tready = (state_r == pmau_pkg::S_IDLE) && !out_valid_r;
    cfg_ready = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata = {6'd0, out_st_r, out_pa_r, out_data_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmau_pkg::S_CLEAR;
      ret_r <= pmau_pkg::S_IDLE;
      clr_r <= '0;
      paging_r <= 1'b0;
      pdb_r <= 32'd0;
      tlbv_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      clr_r <= clr_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index[0] == pmau_pkg::CFG_PAGING_ENABLE) paging_r <= cfg_data[0];
        else pdb_r <= cfg_data;
      end
      if (tlb_we) tlbv_r[slot] <= 1'b1;
      if (state_r == pmau_pkg::S_FIN) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt; addr_r <= addr_nxt; loc_r <= loc_nxt;
    is_wr_r <= is_wr_nxt; part_r <= part_nxt; xwr_r <= xwr_nxt;
    va_r <= va_nxt; wd_r <= wd_nxt; pa_r <= pa_nxt; dl_r <= dl_nxt;
    cva_r <= cva_nxt; ent_r <= ent_nxt; xpa_r <= xpa_nxt;
    acc_r <= acc_nxt; wdat_r <= wdat_nxt; data_r <= data_nxt;
    len_r <= len_nxt; left_r <= left_nxt; n_r <= n_nxt; bcnt_r <= bcnt_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; bit_r <= bit_nxt;
    if (state_r == pmau_pkg::S_FIN) begin
      out_data_r <= (st_r == pmau_pkg::ST_OK) ? data_r : 32'd0;
      out_pa_r   <= pa_r;
      out_st_r   <= st_r;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pmau_ram.sv */
`default_nettype none
module pmau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* tb/paged_access_checker.sv */
`timescale 1ns / 1ps
module paged_access_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               errors,
  output int               outstanding
);

  typedef struct packed {
    logic [31:0]       data;
    logic [31:0]       pa;
    pmau_pkg::status_t st;
  } access_result_t;

  localparam int unsigned NSLOT = pmau_pkg::TLB_ENTRIES_DEF;
  localparam int unsigned MBYTES = pmau_pkg::MEM_BYTES_DEF;
  localparam int unsigned TB = pmau_pkg::TAG_BITS;

  logic [7:0]          mem_image [0:MBYTES-1];
  logic                slot_valid [0:NSLOT-1];
  logic [TB-1:0]       slot_tag [0:NSLOT-1];
  logic [31:0]         slot_pte_loc [0:NSLOT-1];
  logic                paging_on;
  logic [31:0]         dir_base;
  access_result_t      expected_results[$];

  assign outstanding = expected_results.size();

  function automatic bit fits(logic [31:0] addr, int unsigned len);
    return ({32'b0, addr} + 64'(len)) <= 64'(MBYTES);
  endfunction

  function automatic logic [31:0] peek(logic [31:0] addr, int unsigned len);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < len; i++) v |= 32'(mem_image[addr + i]) << (8 * i);
    return v;
  endfunction

  function automatic void poke(logic [31:0] addr, logic [31:0] v, int unsigned len);
    for (int i = 0; i < len; i++) mem_image[addr + i] = v[8*i +: 8];
  endfunction

  function automatic pmau_pkg::status_t walk(logic [31:0] va, bit wr,
                                             output logic [31:0] pa);
    logic [19:0]   vpn;
    int unsigned   slot;
    logic [TB-1:0] tag;
    logic [31:0]   pde_loc, pte_loc, pde, pte;
    pa = '0;
    if (va < pmau_pkg::DIRECT_LIMIT) begin
      pa = va;
      return pmau_pkg::ST_OK;
    end
    vpn = va[31:12];
    tag = {dir_base, vpn};
    slot = vpn % NSLOT;
    if (slot_valid[slot] && slot_tag[slot] == tag) begin
      pte_loc = slot_pte_loc[slot];
      if (!fits(pte_loc, 4)) return pmau_pkg::ST_OUT_RANGE;
      pte = peek(pte_loc, 4) | pmau_pkg::BIT_ACCESSED;
      if (wr) pte |= pmau_pkg::BIT_DIRTY;
      poke(pte_loc, pte, 4);
      pa = (pte & ~pmau_pkg::OFF_MASK) | (va & pmau_pkg::OFF_MASK);
      return pmau_pkg::ST_OK;
    end
    pde_loc = (dir_base & ~pmau_pkg::OFF_MASK) + {20'b0, vpn[19:10], 2'b0};
    if (!fits(pde_loc, 4)) return pmau_pkg::ST_OUT_RANGE;
    pde = peek(pde_loc, 4);
    if (!(pde & pmau_pkg::BIT_PRESENT)) return pmau_pkg::ST_NOT_PRESENT;
    poke(pde_loc, pde | pmau_pkg::BIT_ACCESSED, 4);
    pte_loc = (pde & ~pmau_pkg::OFF_MASK) + {20'b0, vpn[9:0], 2'b0};
    if (!fits(pte_loc, 4)) return pmau_pkg::ST_OUT_RANGE;
    pte = peek(pte_loc, 4);
    if (!(pte & pmau_pkg::BIT_PRESENT)) return pmau_pkg::ST_NOT_PRESENT;
    pte |= pmau_pkg::BIT_ACCESSED;
    if (wr) pte |= pmau_pkg::BIT_DIRTY;
    poke(pte_loc, pte, 4);
    slot_valid[slot] = 1'b1;
    slot_tag[slot] = tag;
    slot_pte_loc[slot] = pte_loc;
    pa = (pte & ~pmau_pkg::OFF_MASK) | (va & pmau_pkg::OFF_MASK);
    return pmau_pkg::ST_OK;
  endfunction

  function automatic access_result_t predict_access(bit wr, logic [31:0] va,
                                                    logic [2:0] len_f, logic [31:0] wd);
    access_result_t r;
    int unsigned    len, left, right;
    logic [31:0]    cb, pb, lo;
    r = '{data: '0, pa: '0, st: pmau_pkg::ST_OK};
    len = (len_f == 0) ? 1 : (len_f > 4) ? 4 : len_f;
    if (!paging_on) begin
      r.pa = va;
      if (!fits(va, len)) r.st = pmau_pkg::ST_OUT_RANGE;
      else if (wr) poke(va, wd, len);
      else r.data = peek(va, len);
    end else if (((va + len - 1) ^ va) >= pmau_pkg::PAGE_BYTES) begin
      if (wr) begin
        r.st = pmau_pkg::ST_CROSS_WR;
      end else begin
        cb = (va + len) & ~pmau_pkg::OFF_MASK;
        left = cb - va;
        right = len - left;
        r.st = walk(va, 1'b0, r.pa);
        if (r.st == pmau_pkg::ST_OK && !fits(r.pa, left)) r.st = pmau_pkg::ST_OUT_RANGE;
        if (r.st == pmau_pkg::ST_OK) begin
          lo = peek(r.pa, left);
          r.st = walk(cb, 1'b0, pb);
          if (r.st == pmau_pkg::ST_OK && !fits(pb, right)) r.st = pmau_pkg::ST_OUT_RANGE;
          if (r.st == pmau_pkg::ST_OK) r.data = lo | (peek(pb, right) << (8 * left));
        end
      end
    end else begin
      r.st = walk(va, wr, r.pa);
      if (r.st == pmau_pkg::ST_OK) begin
        if (!fits(r.pa, len)) r.st = pmau_pkg::ST_OUT_RANGE;
        else if (wr) poke(r.pa, wd, len);
        else r.data = peek(r.pa, len);
      end
    end
    if (r.st != pmau_pkg::ST_OK) r.data = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MBYTES; i++) mem_image[i] = '0;
      for (int i = 0; i < NSLOT; i++) begin
        slot_valid[i] = 1'b0;
        slot_tag[i] = '0;
        slot_pte_loc[i] = '0;
      end
      paging_on = 1'b0;
      dir_base = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pmau_pkg::CFG_PAGING_ENABLE) paging_on = cfg_data[0];
        else dir_base = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer %h", out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.data) begin
            $error("read_data expected %h actual %h", want.data, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== want.pa) begin
            $error("phys_addr expected %h actual %h", want.pa, out_tdata[63:32]);
            errors++;
          end
          if (out_tdata[65:64] !== want.st) begin
            $error("status expected %0d actual %0d", want.st, out_tdata[65:64]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_access(in_tuser[0], in_tdata[31:0],
                                                  in_tdata[34:32], in_tdata[66:35]));
    end
  end

endmodule

/* tb/paged_memory_access_unit_tb.sv */
`timescale 1ns / 1ps
module paged_memory_access_unit_tb;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          outstanding;
  int          cycles;
  bit          no_gaps;
  bit          no_stalls;

  paged_memory_access_unit dut (.*);

  paged_access_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, with stall-free stretches
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) no_stalls = !no_stalls;
      stall = no_stalls ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_access(logic rt, logic [31:0] va, logic [2:0] len, logic [31:0] wd);
    int gap;
    if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rt;
    in_tdata <= {5'b0, wd, len, va};
    do @(posedge clk); while (!in_tready);
  endtask

  // drain everything before touching a register
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // directory at 0x1000, tables at 0x2000..0x5000, data frames 0x6..0xf, at times 0x20
  task automatic build_tables();
    logic [31:0] pde, pte, frame;
    write_reg(pmau_pkg::CFG_PAGING_ENABLE, 32'd0);
    for (int d = 0; d < 4; d++) begin
      pde = (32'h2000 + d * 32'h1000) | ($urandom & 32'hffe);
      if ($urandom_range(0, 9) != 0) pde |= pmau_pkg::BIT_PRESENT;
      if ($urandom_range(0, 19) == 0) pde = 32'h1234_5001;
      send_access(pmau_pkg::REQ_WRITE, 32'h1000 + (32'h20 + d) * 4, 3'd4, pde);
    end
    for (int d = 0; d < 4; d++)
      for (int k = 0; k < 32; k++) begin
        frame = $urandom_range(6, 15);
        if ($urandom_range(0, 19) == 0) frame = 32'h20;
        pte = (frame << 12) | ($urandom & 32'hffe);
        if ($urandom_range(0, 9) != 0) pte |= pmau_pkg::BIT_PRESENT;
        send_access(pmau_pkg::REQ_WRITE, 32'h2000 + d * 32'h1000 + k * 4, 3'd4, pte);
      end
  endtask

  function automatic logic [31:0] mapped_va(int unsigned dir, int unsigned idx);
    logic [11:0] off;
    off = ($urandom_range(0, 3) == 0) ? 12'hffc + 12'($urandom_range(0, 3)) : 12'($urandom);
    return {10'(32'h20 + dir), 10'(idx), off};
  endfunction

  task automatic random_access();
    logic [31:0] va;
    logic [2:0]  len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) va = mapped_va($urandom_range(0, 3), $urandom_range(0, 31));
    else if (pick < 72) va = mapped_va($urandom_range(0, 3), $urandom_range(32, 1023));
    else if (pick < 88) va = $urandom_range(32'h6000, 32'h10003);
    else if (pick < 92) va = $urandom_range(0, 32'h5fff);
    else va = $urandom;
    len = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    send_access($urandom_range(0, 2) == 0, va, len, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // direct accesses: every length code, memory edges, data extremes
    for (int l = 0; l < 8; l++)
      send_access(pmau_pkg::REQ_WRITE, 32'h8000 + l * 8, 3'(l), 32'hffff_ffff);
    for (int l = 0; l < 8; l++) send_access(pmau_pkg::REQ_READ, 32'h8000 + l * 8, 3'(l), '0);
    send_access(pmau_pkg::REQ_WRITE, 32'h0000_fffc, 3'd4, 32'ha5c3_3c5a);
    send_access(pmau_pkg::REQ_READ, 32'h0000_fffc, 3'd4, '0);
    send_access(pmau_pkg::REQ_READ, 32'h0000_fffd, 3'd4, '0);
    send_access(pmau_pkg::REQ_WRITE, 32'hffff_ffff, 3'd1, 32'h0);
    send_access(pmau_pkg::REQ_READ, 32'h0, 3'd4, '0);

    for (int round = 0; round < 3; round++) begin
      build_tables();
      write_reg(pmau_pkg::CFG_PAGE_DIR_BASE, 32'h1000 | $urandom_range(0, 4095));
      write_reg(pmau_pkg::CFG_PAGING_ENABLE, 32'd1);
      if (round == 0) begin
        send_access(pmau_pkg::REQ_READ, {10'h20, 10'd3, 12'h010}, 3'd4, '0);
        send_access(pmau_pkg::REQ_WRITE, {10'h20, 10'd3, 12'h010}, 3'd2, 32'hbeef);
        send_access(pmau_pkg::REQ_READ, {10'h20, 10'd19, 12'h010}, 3'd4, '0); // same tlb slot
        send_access(pmau_pkg::REQ_READ, {10'h20, 10'd3, 12'h010}, 3'd4, '0);
        send_access(pmau_pkg::REQ_WRITE, {10'h21, 10'd5, 12'hffe}, 3'd4, 32'h1);
        send_access(pmau_pkg::REQ_READ, {10'h21, 10'd5, 12'hffe}, 3'd4, '0);
        send_access(pmau_pkg::REQ_READ, 32'h0000_6ffe, 3'd4, '0);
        send_access(pmau_pkg::REQ_WRITE, 32'h0000_6ffe, 3'd3, 32'h7);
        send_access(pmau_pkg::REQ_READ, {10'h30, 10'd0, 12'h0}, 3'd1, '0);    // no directory entry
        send_access(pmau_pkg::REQ_READ, {10'h22, 10'd500, 12'h0}, 3'd1, '0);  // table entry absent
        send_access(pmau_pkg::REQ_READ, 32'hffff_ffff, 3'd4, '0);             // wraps to zero
        send_access(pmau_pkg::REQ_READ, 32'h07ff_fffe, 3'd4, '0);
      end
      for (int n = 0; n < 380; n++) random_access();
    end

    write_reg(pmau_pkg::CFG_PAGE_DIR_BASE, 32'hffff_ffff);
    for (int n = 0; n < 20; n++) random_access();
    write_reg(pmau_pkg::CFG_PAGE_DIR_BASE, 32'h0);
    for (int n = 0; n < 20; n++) random_access();
    write_reg(pmau_pkg::CFG_PAGING_ENABLE, 32'd0);
    for (int n = 0; n < 60; n++) random_access();

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
